>>> rtl/mbe_pkg.sv
package mbe_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int COMP_BITS  = FRAC_BITS + 4;
  localparam int WIDE_W     = 2 * COMP_BITS;
  localparam int SQ_W       = WIDE_W - FRAC_BITS;
  localparam int PIX_W      = 12;
  localparam int ORIGIN_W   = 32;
  localparam int STEP_W     = 31;
  localparam int BOUND_W    = 4;
  localparam int ITER_W     = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PC_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd5;

  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_X = 32'hD800_0000;
  localparam logic [ORIGIN_W-1:0] RST_ORIGIN_Y = 32'hE800_0000;
  localparam logic [STEP_W-1:0]   RST_STEP     = 31'h0010_0000;
  localparam logic [BOUND_W-1:0]  RST_BOUND    = 4'd4;
  localparam logic [ITER_W-1:0]   RST_MAX_ITER = 16'd256;

  localparam logic [2:0] MUL_NONE   = 3'd0;
  localparam logic [2:0] MUL_STEP_X = 3'd1;
  localparam logic [2:0] MUL_STEP_Y = 3'd2;
  localparam logic [2:0] MUL_AA     = 3'd3;
  localparam logic [2:0] MUL_BB     = 3'd4;
  localparam logic [2:0] MUL_AB     = 3'd5;

  localparam logic [1:0] CND_NEXT    = 2'd0;
  localparam logic [1:0] CND_WAIT_IN = 2'd1;
  localparam logic [1:0] CND_LOOP    = 2'd2;
  localparam logic [1:0] CND_OUT     = 2'd3;

  localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] PC_MAP_X = 4'd1;
  localparam logic [PC_W-1:0] PC_MAP_Y = 4'd2;
  localparam logic [PC_W-1:0] PC_INIT  = 4'd3;
  localparam logic [PC_W-1:0] PC_LOOP  = 4'd4;
  localparam logic [PC_W-1:0] PC_SQ_B  = 4'd5;
  localparam logic [PC_W-1:0] PC_CROSS = 4'd6;
  localparam logic [PC_W-1:0] PC_TEST  = 4'd7;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd8;

  typedef struct packed {
    logic [2:0]      mul_sel;
    logic            ld_cre;
    logic            ld_cim;
    logic            ld_aa;
    logic            ld_sums;
    logic            upd;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [2:0] mul_sel;
    logic       cap_in;
    logic       ld_cre;
    logic       ld_cim;
    logic       ld_aa;
    logic       ld_sums;
    logic       cnt;
    logic       upd;
    logic       ld_out;
  } ctrl_t;

  typedef struct packed {
    logic loop_exit;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [BOUND_W-1:0]  bound;
    logic [ITER_W-1:0]   max_iter;
  } cfg_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    w.cond = CND_NEXT;
    case (pc)
      PC_IDLE: begin
        w.cond = CND_WAIT_IN;
      end
      PC_MAP_X: begin
        w.mul_sel = MUL_STEP_X;
      end
      PC_MAP_Y: begin
        w.mul_sel = MUL_STEP_Y;
        w.ld_cre  = 1'b1;
      end
      PC_INIT: begin
        w.ld_cim = 1'b1;
      end
      PC_LOOP: begin
        w.mul_sel = MUL_AA;
      end
      PC_SQ_B: begin
        w.mul_sel = MUL_BB;
        w.ld_aa   = 1'b1;
      end
      PC_CROSS: begin
        w.mul_sel = MUL_AB;
        w.ld_sums = 1'b1;
      end
      PC_TEST: begin
        w.upd    = 1'b1;
        w.cond   = CND_LOOP;
        w.target = PC_LOOP;
      end
      PC_DONE: begin
        w.cond   = CND_OUT;
        w.target = PC_IDLE;
      end
      default: begin
        w.cond   = CND_OUT;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [COMP_BITS-1:0] sat_comp(input logic signed [WIDE_W-1:0] x);
    logic [WIDE_W-COMP_BITS:0] top;
    top = x[WIDE_W-1:COMP_BITS-1];
    if ((&top) || (~|top)) begin
      return x[COMP_BITS-1:0];
    end else if (x[WIDE_W-1]) begin
      return {1'b1, {(COMP_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COMP_BITS-1){1'b1}}};
    end
  endfunction

  function automatic logic [COMP_BITS-1:0] mag_comp(input logic [COMP_BITS-1:0] a);
    logic [COMP_BITS-1:0] m;
    m = a[COMP_BITS-1] ? (~a + 1'b1) : a;
    return m;
  endfunction

endpackage

>>> rtl/mbe_seq.sv
module mbe_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mbe_pkg::stat_t stat,
  output mbe_pkg::ctrl_t ctrl
);

  logic [mbe_pkg::PC_W-1:0] pc_r;
  logic [mbe_pkg::PC_W-1:0] pc_nxt;
  mbe_pkg::ucode_t          uw;

  assign uw = mbe_pkg::ucode_rom(pc_r);

  always_comb begin
    case (uw.cond)
      mbe_pkg::CND_NEXT:    pc_nxt = pc_r + 1'b1;
      mbe_pkg::CND_WAIT_IN: pc_nxt = in_valid ? pc_r + 1'b1 : pc_r;
      mbe_pkg::CND_LOOP:    pc_nxt = stat.loop_exit ? pc_r + 1'b1 : uw.target;
      mbe_pkg::CND_OUT:     pc_nxt = stat.out_free ? uw.target : pc_r;
      default:              pc_nxt = mbe_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mbe_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign in_stall = (uw.cond != mbe_pkg::CND_WAIT_IN);

  always_comb begin
    ctrl.mul_sel = uw.mul_sel;
    ctrl.cap_in  = (uw.cond == mbe_pkg::CND_WAIT_IN) && in_valid;
    ctrl.ld_cre  = uw.ld_cre;
    ctrl.ld_cim  = uw.ld_cim;
    ctrl.ld_aa   = uw.ld_aa;
    ctrl.ld_sums = uw.ld_sums;
    ctrl.cnt     = uw.upd;
    ctrl.upd     = uw.upd && !stat.loop_exit;
    ctrl.ld_out  = (uw.cond == mbe_pkg::CND_OUT) && stat.out_free;
  end

endmodule

>>> rtl/mbe_datapath.sv
module mbe_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mbe_pkg::cfg_t               cfg,
  input  mbe_pkg::ctrl_t              ctrl,
  output mbe_pkg::stat_t              stat,
  input  logic [mbe_pkg::PIX_W-1:0]   pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]   pixel_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mbe_pkg::PIX_W-1:0]   out_x,
  output logic [mbe_pkg::PIX_W-1:0]   out_y,
  output logic [mbe_pkg::ITER_W-1:0]  out_count
);

  localparam int CW = mbe_pkg::COMP_BITS;
  localparam int WW = mbe_pkg::WIDE_W;
  localparam int SW = mbe_pkg::SQ_W;
  localparam int FB = mbe_pkg::FRAC_BITS;

  logic [mbe_pkg::COORD_BITS-1:0] px_r, py_r;
  logic [WW-1:0]                  p_r;
  logic [CW-1:0]                  cre_r, cim_r, a_r, b_r;
  logic [SW-1:0]                  aa_r;
  logic [SW:0]                    sum_r;
  logic signed [SW:0]             diff_r;
  logic [mbe_pkg::ITER_W-1:0]     n_r;
  logic [mbe_pkg::PIX_W-1:0]      out_x_r, out_y_r;
  logic [mbe_pkg::ITER_W-1:0]     out_cnt_r;
  logic                           out_valid_r;

  logic [CW-1:0]                  op_a, op_b;
  logic [WW-1:0]                  prod;
  logic [CW-1:0]                  mag_a, mag_b;
  logic signed [WW-1:0]           org_x_w, org_y_w;
  logic [CW-1:0]                  cre_nxt, cim_nxt, re_nxt, im_nxt;
  logic [SW-1:0]                  bb;
  logic [SW:0]                    ab;
  logic signed [WW-1:0]           ab_w, im_term;
  logic [SW:0]                    thr;
  logic [mbe_pkg::ITER_W-1:0]     n_inc;

  assign mag_a = mbe_pkg::mag_comp(a_r);
  assign mag_b = mbe_pkg::mag_comp(b_r);

  always_comb begin
    case (ctrl.mul_sel)
      mbe_pkg::MUL_STEP_X: begin
        op_a = CW'(cfg.step_x);
        op_b = CW'(px_r);
      end
      mbe_pkg::MUL_STEP_Y: begin
        op_a = CW'(cfg.step_y);
        op_b = CW'(py_r);
      end
      mbe_pkg::MUL_AA: begin
        op_a = mag_a;
        op_b = mag_a;
      end
      mbe_pkg::MUL_BB: begin
        op_a = mag_b;
        op_b = mag_b;
      end
      mbe_pkg::MUL_AB: begin
        op_a = mag_a;
        op_b = mag_b;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = WW'(op_a) * WW'(op_b);

  assign org_x_w = WW'($signed(cfg.origin_x));
  assign org_y_w = WW'($signed(cfg.origin_y));
  assign cre_nxt = mbe_pkg::sat_comp(org_x_w + $signed(p_r));
  assign cim_nxt = mbe_pkg::sat_comp(org_y_w + $signed(p_r));

  assign bb      = p_r[WW-1:FB];
  assign ab      = p_r[WW-1:FB-1];
  assign ab_w    = $signed(WW'(ab));
  assign im_term = (a_r[CW-1] ^ b_r[CW-1]) ? -ab_w : ab_w;
  assign re_nxt  = mbe_pkg::sat_comp(WW'(diff_r) + WW'($signed(cre_r)));
  assign im_nxt  = mbe_pkg::sat_comp(im_term + WW'($signed(cim_r)));

  assign thr            = (SW + 1)'({cfg.bound, {FB{1'b0}}});
  assign n_inc          = n_r + 1'b1;
  assign stat.loop_exit = (n_inc >= cfg.max_iter) || !(sum_r < thr);
  assign stat.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (ctrl.cap_in) begin
      px_r <= mbe_pkg::COORD_BITS'(pixel_x);
      py_r <= mbe_pkg::COORD_BITS'(pixel_y);
    end
    if (ctrl.mul_sel != mbe_pkg::MUL_NONE) begin
      p_r <= prod;
    end
    if (ctrl.ld_cre) begin
      cre_r <= cre_nxt;
    end
    if (ctrl.ld_cim) begin
      cim_r <= cim_nxt;
      a_r   <= cre_r;
      b_r   <= cim_nxt;
      n_r   <= '0;
    end
    if (ctrl.ld_aa) begin
      aa_r <= p_r[WW-1:FB];
    end
    if (ctrl.ld_sums) begin
      sum_r  <= {1'b0, aa_r} + {1'b0, bb};
      diff_r <= $signed({1'b0, aa_r}) - $signed({1'b0, bb});
    end
    if (ctrl.cnt) begin
      n_r <= n_inc;
    end
    if (ctrl.upd) begin
      a_r <= re_nxt;
      b_r <= im_nxt;
    end
    if (ctrl.ld_out) begin
      out_x_r   <= mbe_pkg::PIX_W'(px_r);
      out_y_r   <= mbe_pkg::PIX_W'(py_r);
      out_cnt_r <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_count = out_cnt_r;

endmodule

>>> rtl/mandelbrot_escape_time.sv
// Escape-time evaluator for one pixel at a time. A pixel transaction is mapped
// to the point c, then z = z*z + c is iterated from z = c in signed Q4.28 until
// the count reaches max_iterations or re^2 + im^2 is no longer below
// escape_bound. One 32x32 multiplier, shared under a small microcode program,
// forms the step*pixel products for c, then re^2, im^2 and re*im in turn in
// each iteration. The next pixel is taken while the previous result waits in
// the output register. Configuration may be written only while no pixel is in
// flight.
module mandelbrot_escape_time (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mbe_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]         in_pixel_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mbe_pkg::PIX_W-1:0]         out_x,
  output logic [mbe_pkg::PIX_W-1:0]         out_y,
  output logic [mbe_pkg::ITER_W-1:0]        out_iteration_count,
  input  logic                              cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]         cfg_wdata
);

  mbe_pkg::cfg_t  cfg_r;
  mbe_pkg::ctrl_t ctrl;
  mbe_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= mbe_pkg::RST_ORIGIN_X;
      cfg_r.origin_y <= mbe_pkg::RST_ORIGIN_Y;
      cfg_r.step_x   <= mbe_pkg::RST_STEP;
      cfg_r.step_y   <= mbe_pkg::RST_STEP;
      cfg_r.bound    <= mbe_pkg::RST_BOUND;
      cfg_r.max_iter <= mbe_pkg::RST_MAX_ITER;
    end else if (cfg_we) begin
      case (cfg_index)
        mbe_pkg::REG_ORIGIN_X: cfg_r.origin_x <= cfg_wdata[mbe_pkg::ORIGIN_W-1:0];
        mbe_pkg::REG_ORIGIN_Y: cfg_r.origin_y <= cfg_wdata[mbe_pkg::ORIGIN_W-1:0];
        mbe_pkg::REG_STEP_X:   cfg_r.step_x   <= cfg_wdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_STEP_Y:   cfg_r.step_y   <= cfg_wdata[mbe_pkg::STEP_W-1:0];
        mbe_pkg::REG_BOUND:    cfg_r.bound    <= cfg_wdata[mbe_pkg::BOUND_W-1:0];
        mbe_pkg::REG_MAX_ITER: cfg_r.max_iter <= cfg_wdata[mbe_pkg::ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  mbe_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .ctrl      (ctrl),
    .stat      (stat),
    .pixel_x   (in_pixel_x),
    .pixel_y   (in_pixel_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_count (out_iteration_count)
  );

endmodule

>>> rtl/mbe_checker.sv
module mbe_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [mbe_pkg::PIX_W-1:0]        out_x,
  input logic [mbe_pkg::PIX_W-1:0]        out_y,
  input logic [mbe_pkg::ITER_W-1:0]       out_iteration_count
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_iteration_count))
    else $error("stalled result changed");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_iteration_count != '0)
    else $error("iteration count of zero");

  // Only one pixel is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a pixel is in flight");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while the block was idle");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_x               (out_x),
  .out_y               (out_y),
  .out_iteration_count (out_iteration_count)
);
